[sv/iqw_pkg.sv]
package iqw_pkg;

    // Fixed-point constants, all Q30 unless noted.
    localparam logic [30:0] Q30_ONE       = 31'h4000_0000;
    localparam logic [29:0] Q30_EIGHTH    = 30'h2000_0000;
    localparam logic [30:0] PI_HALF_Q30   = 31'd1686629713;
    localparam logic [28:0] HAMMING_B_Q30 = 29'd493921239;
    localparam logic [29:0] BLACK_A_Q30   = 30'd901943132;
    localparam logic [26:0] BLACK_C_Q30   = 27'd85899346;

    // Unit weight in Q1.16.
    localparam logic [16:0] WEIGHT_ONE = 17'h1_0000;

    // Reciprocal constants for exact truncating division of values below 2^30.
    localparam int unsigned DIV6_S  = 33;
    localparam int unsigned DIV12_S = 34;
    localparam int unsigned DIV20_S = 35;
    localparam int unsigned DIV30_S = 35;
    localparam int unsigned DIV42_S = 36;
    localparam int unsigned DIV56_S = 36;
    localparam int unsigned DIV72_S = 37;
    localparam logic [31:0] DIV6_M  = 32'(((64'd1 << DIV6_S)  + 64'd5)  / 64'd6);
    localparam logic [31:0] DIV12_M = 32'(((64'd1 << DIV12_S) + 64'd11) / 64'd12);
    localparam logic [31:0] DIV20_M = 32'(((64'd1 << DIV20_S) + 64'd19) / 64'd20);
    localparam logic [31:0] DIV30_M = 32'(((64'd1 << DIV30_S) + 64'd29) / 64'd30);
    localparam logic [31:0] DIV42_M = 32'(((64'd1 << DIV42_S) + 64'd41) / 64'd42);
    localparam logic [31:0] DIV56_M = 32'(((64'd1 << DIV56_S) + 64'd55) / 64'd56);
    localparam logic [31:0] DIV72_M = 32'(((64'd1 << DIV72_S) + 64'd71) / 64'd72);

    // Pipeline depth of the cosine unit.
    localparam int COS_LAT = 11;

    // Configuration port.
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [15:0] LENGTH_RESET = 16'd1024;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_KIND   = 2'd0,
        CFG_LENGTH = 2'd1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        WIN_RECT     = 2'd0,
        WIN_HANN     = 2'd1,
        WIN_HAMMING  = 2'd2,
        WIN_BLACKMAN = 2'd3
    } t_window_kind;

    // Q30 product of two values no larger than 2^30 (or x < 2^31 times y < 2^30).
    function automatic logic [30:0] mul_q30(logic [30:0] a, logic [30:0] b);
        logic [63:0] pr;
        pr = 64'(a) * 64'(b);
        return 31'(pr >> 30);
    endfunction

    // Truncating division by a small constant through its reciprocal.
    function automatic logic [29:0] div_k(logic [29:0] v, logic [31:0] m, int unsigned s);
        logic [63:0] pr;
        pr = 64'(v) * 64'(m);
        return 30'(pr >> s);
    endfunction

endpackage

[sv/iqw_in_if.sv]
interface iqw_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_i;
    logic signed [SAMPLE_BITS-1:0] sample_q;

    modport source (output valid, output sample_i, output sample_q, input ready);
    modport sink   (input valid, input sample_i, input sample_q, output ready);
endinterface

[sv/iqw_out_if.sv]
interface iqw_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] windowed_i;
    logic signed [SAMPLE_BITS-1:0] windowed_q;
    logic                          frame_last;

    modport source (output valid, output windowed_i, output windowed_q, output frame_last,
                    input ready);
    modport sink   (input valid, input windowed_i, input windowed_q, input frame_last,
                    output ready);
endinterface

[sv/iqw_cos.sv]
// Pipelined cos(2*pi*p) + 1 in Q30 by quadrant folding and Taylor polynomials.
module iqw_cos (
    input  logic                         i_clk,
    input  logic [iqw_pkg::COS_LAT-1:0]  i_en,
    input  logic [31:0]                  i_phase,
    output logic [31:0]                  o_cu
);
    logic [1:0]  r_quad   [0:9];
    logic        r_mirror [0:9];
    logic [29:0] r_x      [0:8];
    logic [29:0] r_x2     [1:6];
    logic [30:0] r_ct2, r_ct4, r_ct6, r_c8, r_c9;
    logic [30:0] r_st2, r_st4, r_st6, r_st8, r_s9;
    logic [29:0] r_cm3, r_cm5, r_cm7;
    logic [29:0] r_sm3, r_sm5, r_sm7;
    logic [31:0] r_cu10;

    logic [29:0] frac;
    logic        mirror;
    logic [29:0] fold;
    logic [30:0] cq, sq;
    logic [31:0] n_cu;

    // Quadrant fold and mirror about one eighth of a turn.
    always_comb begin
        frac   = i_phase[29:0];
        mirror = frac > iqw_pkg::Q30_EIGHTH;
        fold   = mirror ? 30'(iqw_pkg::Q30_ONE - 31'(frac)) : frac;
    end

    // Stages 0 and 1 form the angle in radians and its square; the fold flags
    // and the angle are carried along the pipe.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_quad[0]   <= i_phase[31:30];
            r_mirror[0] <= mirror;
            r_x[0]      <= 30'(iqw_pkg::mul_q30(31'(fold), iqw_pkg::PI_HALF_Q30));
        end
        if (i_en[1]) begin
            r_x2[1] <= 30'(iqw_pkg::mul_q30(31'(r_x[0]), 31'(r_x[0])));
        end
        for (int j = 1; j <= 9; j++) begin
            if (i_en[j]) begin
                r_quad[j]   <= r_quad[j-1];
                r_mirror[j] <= r_mirror[j-1];
            end
        end
        for (int j = 1; j <= 8; j++) begin
            if (i_en[j]) begin
                r_x[j] <= r_x[j-1];
            end
        end
        for (int j = 2; j <= 6; j++) begin
            if (i_en[j]) begin
                r_x2[j] <= r_x2[j-1];
            end
        end
    end

    // Horner steps: a divide stage, then a multiply stage, alternating.
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_ct2 <= iqw_pkg::Q30_ONE - 31'(iqw_pkg::div_k(r_x2[1], iqw_pkg::DIV56_M,
                                                            iqw_pkg::DIV56_S));
            r_st2 <= iqw_pkg::Q30_ONE - 31'(iqw_pkg::div_k(r_x2[1], iqw_pkg::DIV72_M,
                                                            iqw_pkg::DIV72_S));
        end
        if (i_en[3]) begin
            r_cm3 <= 30'(iqw_pkg::mul_q30(31'(r_x2[2]), r_ct2));
            r_sm3 <= 30'(iqw_pkg::mul_q30(31'(r_x2[2]), r_st2));
        end
        if (i_en[4]) begin
            r_ct4 <= iqw_pkg::Q30_ONE - 31'(iqw_pkg::div_k(r_cm3, iqw_pkg::DIV30_M,
                                                            iqw_pkg::DIV30_S));
            r_st4 <= iqw_pkg::Q30_ONE - 31'(iqw_pkg::div_k(r_sm3, iqw_pkg::DIV42_M,
                                                            iqw_pkg::DIV42_S));
        end
        if (i_en[5]) begin
            r_cm5 <= 30'(iqw_pkg::mul_q30(31'(r_x2[4]), r_ct4));
            r_sm5 <= 30'(iqw_pkg::mul_q30(31'(r_x2[4]), r_st4));
        end
        if (i_en[6]) begin
            r_ct6 <= iqw_pkg::Q30_ONE - 31'(iqw_pkg::div_k(r_cm5, iqw_pkg::DIV12_M,
                                                            iqw_pkg::DIV12_S));
            r_st6 <= iqw_pkg::Q30_ONE - 31'(iqw_pkg::div_k(r_sm5, iqw_pkg::DIV20_M,
                                                            iqw_pkg::DIV20_S));
        end
        if (i_en[7]) begin
            r_cm7 <= 30'(iqw_pkg::mul_q30(31'(r_x2[6]), r_ct6));
            r_sm7 <= 30'(iqw_pkg::mul_q30(31'(r_x2[6]), r_st6));
        end
        if (i_en[8]) begin
            r_c8  <= iqw_pkg::Q30_ONE - 31'(r_cm7 >> 1);
            r_st8 <= iqw_pkg::Q30_ONE - 31'(iqw_pkg::div_k(r_sm7, iqw_pkg::DIV6_M,
                                                            iqw_pkg::DIV6_S));
        end
        if (i_en[9]) begin
            r_c9 <= r_c8;
            r_s9 <= iqw_pkg::mul_q30(31'(r_x[8]), r_st8);
        end
        if (i_en[10]) begin
            r_cu10 <= n_cu;
        end
    end

    // Undo the fold and add one.
    always_comb begin
        cq = r_mirror[9] ? r_s9 : r_c9;
        sq = r_mirror[9] ? r_c9 : r_s9;
        case (r_quad[9])
            2'd0:    n_cu = 32'(iqw_pkg::Q30_ONE) + 32'(cq);
            2'd1:    n_cu = 32'(iqw_pkg::Q30_ONE) - 32'(sq);
            2'd2:    n_cu = 32'(iqw_pkg::Q30_ONE) - 32'(cq);
            default: n_cu = 32'(iqw_pkg::Q30_ONE) + 32'(sq);
        endcase
    end

    assign o_cu = r_cu10;

endmodule

[sv/iq_window_apply.sv]
// An accepted input beat passes through 16 register stages to its output beat.
// Throughput: one beat per cycle while the divider is idle and the output is ready;
// per-stage valid bits let a stall fill bubbles. The phase step 2^32/(N-1) comes
// from a one-bit-per-cycle divider that runs after reset and after each window_length
// write; input is not ready while it runs. Synchronous active-low reset clears the
// pipeline valid bits, sample index and registers (kind rectangular, length 1024).
module iq_window_apply #(
    parameter int INDEX_BITS  = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [iqw_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [iqw_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    iqw_in_if.sink                            i_in,
    iqw_out_if.source                         o_out
);
    localparam int NS  = iqw_pkg::COS_LAT + 5;
    localparam int CW  = (INDEX_BITS > 16) ? INDEX_BITS : 16;
    localparam int PW  = SAMPLE_BITS + 18;
    localparam int SMP_LAST = NS - 3;

    // Configuration and phase state.
    iqw_pkg::t_window_kind r_kind;
    logic [15:0]           r_len;
    logic [INDEX_BITS-1:0] r_index;
    logic [31:0]           r_acc_q;
    logic [15:0]           r_acc_r;

    // Step divider.
    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [15:0] r_rem;
    logic [31:0] r_quo;

    // Pipeline.
    logic [NS-1:0]                 r_vld;
    logic [NS-1:0]                 en;
    logic signed [SAMPLE_BITS-1:0] r_si [0:SMP_LAST];
    logic signed [SAMPLE_BITS-1:0] r_sq [0:SMP_LAST];
    logic                          r_last [0:NS-1];
    logic [31:0]                   r_phase;
    logic [31:0]                   cu, c2u;
    logic [30:0]                   r_half, r_hamp, r_blkp;
    logic [16:0]                   r_wq;
    logic signed [PW-1:0]          r_pi, r_pq;
    logic signed [SAMPLE_BITS-1:0] r_oi, r_oq;

    logic [15:0]     d_len;
    logic            last_c;
    logic [INDEX_BITS-1:0] idx_inc;
    logic            wrap;
    logic [16:0]     sum_r;
    logic            carry;
    logic            accept;
    logic [16:0]     rem2;
    logic            fits;

    // Index bookkeeping: divisor is N-1, with N of zero treated as one.
    always_comb begin
        d_len   = (r_len == 16'd0) ? 16'd0 : r_len - 16'd1;
        last_c  = CW'(r_index) >= CW'(d_len);
        idx_inc = r_index + INDEX_BITS'(1);
        wrap    = last_c || (idx_inc == '0);
        sum_r   = {1'b0, r_acc_r} + {1'b0, r_rem};
        carry   = sum_r >= {1'b0, d_len};
        rem2    = {r_rem, (r_cnt == 6'd32)};
        fits    = rem2 >= {1'b0, d_len};
    end

    assign accept     = i_in.valid && i_in.ready;
    assign i_in.ready = en[0] && !r_busy;

    // Stage enables: a stage loads when it is empty or its successor moves.
    always_comb begin
        en[NS-1] = !r_vld[NS-1] || o_out.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    // Configuration writes, index and phase accumulator, step divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= iqw_pkg::WIN_RECT;
            r_len   <= iqw_pkg::LENGTH_RESET;
            r_index <= '0;
            r_acc_q <= '0;
            r_acc_r <= '0;
            r_busy  <= 1'b1;
            r_cnt   <= 6'd32;
            r_rem   <= '0;
        end else begin
            if (r_busy) begin
                r_rem <= fits ? 16'(rem2 - {1'b0, d_len}) : 16'(rem2);
                r_quo <= {r_quo[30:0], fits};
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 6'd1;
                end
            end
            if (accept) begin
                if (wrap) begin
                    r_index <= '0;
                    r_acc_q <= '0;
                    r_acc_r <= '0;
                end else begin
                    r_index <= idx_inc;
                    r_acc_q <= r_acc_q + r_quo + 32'(carry);
                    r_acc_r <= carry ? 16'(sum_r - {1'b0, d_len}) : 16'(sum_r);
                end
            end
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    iqw_pkg::CFG_KIND: begin
                        r_kind <= iqw_pkg::t_window_kind'(i_cfg_data[1:0]);
                    end
                    iqw_pkg::CFG_LENGTH: begin
                        r_len   <= i_cfg_data;
                        r_index <= '0;
                        r_acc_q <= '0;
                        r_acc_r <= '0;
                        r_busy  <= 1'b1;
                        r_cnt   <= 6'd32;
                        r_rem   <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Valid bits travel with the beats.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= accept;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 0 captures the beat and its phase; samples and flag ride along.
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_si[0]   <= i_in.sample_i;
            r_sq[0]   <= i_in.sample_q;
            r_last[0] <= last_c;
            r_phase   <= r_acc_q;
        end
        for (int k = 1; k <= SMP_LAST; k++) begin
            if (en[k]) begin
                r_si[k] <= r_si[k-1];
                r_sq[k] <= r_sq[k-1];
            end
        end
        for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
                r_last[k] <= r_last[k-1];
            end
        end
    end

    // Cosine at the phase and at twice the phase.
    iqw_cos u_cos1 (
        .i_clk   (i_clk),
        .i_en    (en[iqw_pkg::COS_LAT:1]),
        .i_phase (r_phase),
        .o_cu    (cu)
    );

    iqw_cos u_cos2 (
        .i_clk   (i_clk),
        .i_en    (en[iqw_pkg::COS_LAT:1]),
        .i_phase ({r_phase[30:0], 1'b0}),
        .o_cu    (c2u)
    );

    // Weight terms.
    always_ff @(posedge i_clk) begin
        if (en[NS-4]) begin
            r_half <= 31'(cu >> 1);
            r_hamp <= 31'((64'(iqw_pkg::HAMMING_B_Q30) * 64'(cu)) >> 30);
            r_blkp <= 31'((64'(iqw_pkg::BLACK_C_Q30) * 64'(c2u)) >> 30);
        end
    end

    // Combine, clamp and round the weight to Q1.16.
    logic signed [33:0] w;
    logic signed [33:0] wc;
    logic [16:0]        n_wq;
    always_comb begin
        case (r_kind)
            iqw_pkg::WIN_HANN:
                w = 34'(iqw_pkg::Q30_ONE) - 34'(r_half);
            iqw_pkg::WIN_HAMMING:
                w = 34'(iqw_pkg::Q30_ONE) - 34'(r_hamp);
            default:
                w = 34'(iqw_pkg::BLACK_A_Q30) - 34'(r_half) + 34'(r_blkp);
        endcase
        if (w < 0) begin
            wc = '0;
        end else if (w > 34'(iqw_pkg::Q30_ONE)) begin
            wc = 34'(iqw_pkg::Q30_ONE);
        end else begin
            wc = w;
        end
        if (r_kind == iqw_pkg::WIN_RECT || r_len < 16'd2) begin
            n_wq = iqw_pkg::WEIGHT_ONE;
        end else begin
            n_wq = 17'((wc + 34'sd8192) >>> 14);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NS-3]) begin
            r_wq <= n_wq;
        end
    end

    // Multiply with the half-LSB offset, then floor-shift to Q1.15.
    always_ff @(posedge i_clk) begin
        if (en[NS-2]) begin
            r_pi <= PW'(r_si[SMP_LAST]) * $signed(PW'({1'b0, r_wq})) + PW'(32768);
            r_pq <= PW'(r_sq[SMP_LAST]) * $signed(PW'({1'b0, r_wq})) + PW'(32768);
        end
        if (en[NS-1]) begin
            r_oi <= SAMPLE_BITS'(r_pi >>> 16);
            r_oq <= SAMPLE_BITS'(r_pq >>> 16);
        end
    end

    assign o_out.valid      = r_vld[NS-1];
    assign o_out.windowed_i = r_oi;
    assign o_out.windowed_q = r_oq;
    assign o_out.frame_last = r_last[NS-1];

    // The remainder of the phase accumulator stays below the divisor.
    a_acc_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_busy && d_len != 16'd0) |-> (r_acc_r < d_len))
        else $error("phase remainder out of range");

    // The step remainder left by the divider is below the divisor.
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(r_busy) && d_len != 16'd0) |-> (r_rem < d_len))
        else $error("divider remainder out of range");

    // The last sample of a window restarts the index and phase.
    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && last_c && !i_cfg_we) |=> (r_index == '0 && r_acc_q == '0))
        else $error("index did not wrap after last sample");

    // A length write restarts the divider and the index.
    a_len_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_addr == iqw_pkg::CFG_LENGTH) |=> (r_busy && r_index == '0))
        else $error("length write did not restart");

endmodule
